>>> rtl/tcr_pkg.sv
// ----------------------------------------------------------------------------
// Tick catch-up reconciler package
// Shared widths, register indexes, reset values, state type and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tcr_pkg;

    localparam int TIME_W      = 32;
    localparam int PERIOD_W    = 20;
    localparam int CATCHUP_W   = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int DIV_STEPS   = TIME_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [CFG_INDEX_W-1:0] REG_TICK_PERIOD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CATCHUP = CFG_INDEX_W'(1);

    localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = PERIOD_W'(10000);
    localparam logic [CATCHUP_W-1:0] CATCHUP_RESET = CATCHUP_W'(100);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } tcr_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } tcr_cmd_t;

    typedef struct packed {
        logic div_last;
    } tcr_status_t;

endpackage

>>> rtl/tcr_ctrl.sv
// ----------------------------------------------------------------------------
// Tick catch-up reconciler controller
// Sequences acceptance, the bit-serial divide and the result hand-over, and
// owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module tcr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tcr_pkg::tcr_cmd_t    cmd,
    input  tcr_pkg::tcr_status_t status
);
    import tcr_pkg::*;

    tcr_state_t state_reg;
    tcr_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/tcr_dp.sv
// ----------------------------------------------------------------------------
// Tick catch-up reconciler datapath
// Holds the configuration, the reference time and the tick total, divides the
// elapsed time by the period one quotient bit per cycle and forms the result.
// ----------------------------------------------------------------------------
module tcr_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [tcr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tcr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [tcr_pkg::TIME_W-1:0]         now_us,
    input  tcr_pkg::tcr_cmd_t                  cmd,
    output tcr_pkg::tcr_status_t               status,
    output logic [tcr_pkg::CATCHUP_W-1:0]      ticks_added,
    output logic [tcr_pkg::TIME_W-1:0]         tick_count,
    output logic                               resynced
);
    import tcr_pkg::*;

    logic [PERIOD_W-1:0]  period_reg;
    logic [CATCHUP_W-1:0] catchup_reg;
    logic                 have_ref_reg;
    logic [TIME_W-1:0]    ref_reg;
    logic [TIME_W-1:0]    total_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    quot_reg;
    logic [PERIOD_W-1:0]  rem_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [CATCHUP_W-1:0] ticks_reg;
    logic                 resynced_reg;

    logic [PERIOD_W-1:0]  period_eff;
    logic [CATCHUP_W-1:0] limit_eff;
    logic [PERIOD_W:0]    trial;
    logic                 trial_ge;
    logic [PERIOD_W-1:0]  rem_next;
    logic [TIME_W-1:0]    ref_next;
    logic [CATCHUP_W-1:0] ticks_next;
    logic                 resynced_next;

    assign period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign limit_eff  = (catchup_reg == '0) ? CATCHUP_W'(1) : catchup_reg;

    assign trial    = {rem_reg, quot_reg[TIME_W-1]};
    assign trial_ge = trial >= {1'b0, period_eff};
    assign rem_next = trial_ge ? PERIOD_W'(trial - {1'b0, period_eff})
                               : trial[PERIOD_W-1:0];

    assign status.div_last = (step_reg == STEP_W'(DIV_STEPS - 1));

    // The new reference is now minus the remainder, or now on a resync.
    always_comb
    begin
        ref_next      = now_reg;
        ticks_next    = CATCHUP_W'(1);
        resynced_next = 1'b1;
        if (have_ref_reg && (quot_reg != '0))
        begin
            if (quot_reg > {{(TIME_W - CATCHUP_W){1'b0}}, limit_eff})
            begin
                ticks_next = limit_eff;
            end
            else
            begin
                ticks_next    = quot_reg[CATCHUP_W-1:0];
                ref_next      = now_reg - {{(TIME_W - PERIOD_W){1'b0}}, rem_reg};
                resynced_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= PERIOD_RESET;
            catchup_reg  <= CATCHUP_RESET;
            have_ref_reg <= 1'b0;
            ref_reg      <= '0;
            total_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_TICK_PERIOD: period_reg  <= cfg_data[PERIOD_W-1:0];
                    REG_MAX_CATCHUP: catchup_reg <= cfg_data[CATCHUP_W-1:0];
                    default:         period_reg  <= period_reg;
                endcase
            end
            if (cmd.finish)
            begin
                have_ref_reg <= 1'b1;
                ref_reg      <= ref_next;
                total_reg    <= total_reg + {{(TIME_W - CATCHUP_W){1'b0}}, ticks_next};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg  <= now_us;
            quot_reg <= now_us - ref_reg;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.step)
        begin
            quot_reg <= {quot_reg[TIME_W-2:0], trial_ge};
            rem_reg  <= rem_next;
            step_reg <= step_reg + STEP_W'(1);
        end
        if (cmd.finish)
        begin
            ticks_reg    <= ticks_next;
            resynced_reg <= resynced_next;
        end
    end

    assign ticks_added = ticks_reg;
    assign tick_count  = total_reg;
    assign resynced    = resynced_reg;

endmodule

>>> rtl/tick_catchup_reconciler_core.sv
// ----------------------------------------------------------------------------
// Tick catch-up reconciler
// Each item is one tick interrupt carrying the free-running microsecond
// counter. The first item after reset seeds the reference and counts one
// tick. Later items credit the whole tick periods elapsed since the
// reference, clamped to the catch-up limit, and keep the remainder so the
// tick clock does not drift. An early interrupt or a clamp resyncs the
// reference to the current time and sets resynced.
// The input channel takes an item when in_valid is high and in_stall is low.
// One result item follows each input item on the output channel. The block
// takes no new item until the last one is in the output register; its
// 32-step restoring divider produces one quotient bit per cycle.
// A result waiting under out_stall does not block the next input item, which
// is divided meanwhile and then held until the output register is free.
// Reset clears the reference, the tick total and the output valid flag, and
// loads the period and catch-up limit with their defaults. Configuration is
// written through cfg_write, cfg_index and cfg_data; the user must write it
// only while the block is idle (not enforced); unknown indexes are ignored.
// ----------------------------------------------------------------------------
module tick_catchup_reconciler_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [tcr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tcr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [tcr_pkg::TIME_W-1:0]         now_us,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [tcr_pkg::CATCHUP_W-1:0]      ticks_added,
    output logic [tcr_pkg::TIME_W-1:0]         tick_count,
    output logic                               resynced
);
    import tcr_pkg::*;

    tcr_cmd_t    cmd;
    tcr_status_t status;

    tcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    tcr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .now_us      (now_us),
        .cmd         (cmd),
        .status      (status),
        .ticks_added (ticks_added),
        .tick_count  (tick_count),
        .resynced    (resynced)
    );

endmodule
